// ===== design/polynomial_multiplier_defines.svh =====
// assertion macros for the polynomial multiplier checker
// no dependencies; included by files that carry assertions
`ifndef POLYNOMIAL_MULTIPLIER_DEFINES_SVH
`define POLYNOMIAL_MULTIPLIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polynomial multiplier check failed");

// next-cycle implication, disabled during reset
`define PM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polynomial multiplier check failed");

`endif

// ===== design/pm_pkg.sv =====
// shared constants and types for the polynomial multiplier
// no dependencies
package pm_pkg;

   localparam int MAX_TERMS = 16;
   localparam int LANES     = 4;
   localparam int LNW       = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PASSES    = (MAX_TERMS + LANES - 1) / LANES;
   localparam int PW        = (PASSES > 1) ? $clog2(PASSES) : 1;
   localparam int CW        = $clog2(MAX_TERMS + 1);
   localparam int DW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int TW        = $clog2(2 * MAX_TERMS);
   localparam int MAX_RES   = 2 * MAX_TERMS - 1;
   localparam int COEF_W    = 32;
   localparam int PROD_W    = 64;
   localparam int ACC_W     = 66 + $clog2(MAX_TERMS);
   localparam int POWER_W   = 5;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;

   // travels with each issued pass through the lanes and the merge stages
   typedef struct packed {
      logic          valid;
      logic          first;
      logic          last;
      logic [TW-1:0] power;
   } tag_type;

   // finished term from the merge stage
   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [TW-1:0]     power;
      logic [COEF_W-1:0] value;
   } res_type;

endpackage

// ===== design/pm_store.sv =====
// banked coefficient stores, one bank per lane, with per-lane operand selection
// depends on pm_pkg
module pm_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [pm_pkg::CW-1:0]             wr_addr,
   input  logic signed [pm_pkg::COEF_W-1:0]  wr_first,
   input  logic signed [pm_pkg::COEF_W-1:0]  wr_second,
   input  logic [pm_pkg::PW-1:0]             pass,
   input  logic [pm_pkg::TW-1:0]             power,
   input  logic [pm_pkg::CW-1:0]             count,
   output logic signed [pm_pkg::COEF_W-1:0]  op_a [pm_pkg::LANES],
   output logic signed [pm_pkg::COEF_W-1:0]  op_b [pm_pkg::LANES]
);
   import pm_pkg::*;

   logic signed [COEF_W-1:0] a_bank [LANES][PASSES];
   logic signed [COEF_W-1:0] b_bank [LANES][PASSES];
   logic signed [COEF_W-1:0] b_rd   [LANES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         a_bank[wr_addr[LNW-1:0]][PW'(wr_addr >> LNW)] <= wr_first;
         b_bank[wr_addr[LNW-1:0]][PW'(wr_addr >> LNW)] <= wr_second;
      end
   end

   // second bank b feeds the lane whose j lands in it: lane = (power - b) mod lanes
   always_comb begin
      logic [LNW-1:0] lane;
      logic [TW:0]    j;
      for (int b = 0; b < LANES; b++) begin
         lane    = LNW'(power - TW'(b));
         j       = {1'b0, power} - (TW + 1)'({pass, lane});
         b_rd[b] = b_bank[b][j[LNW +: PW]];
      end
   end

   always_comb begin
      logic [TW:0] i;
      logic [TW:0] j;
      logic        ok;
      for (int l = 0; l < LANES; l++) begin
         i  = (TW + 1)'({pass, LNW'(l)});
         j  = {1'b0, power} - i;
         ok = (i[TW-1:0] < TW'(count)) && !j[TW] && (j[TW-1:0] < TW'(count));
         op_a[l] = ok ? a_bank[l][pass] : '0;
         op_b[l] = ok ? b_rd[j[LNW-1:0]] : '0;
      end
   end

endmodule

// ===== design/pm_lane.sv =====
// one multiplier lane: registered signed 32x32 coefficient product
// depends on pm_pkg
module pm_lane (
   input  logic                              clock,
   input  logic signed [pm_pkg::COEF_W-1:0]  op_a,
   input  logic signed [pm_pkg::COEF_W-1:0]  op_b,
   output logic signed [pm_pkg::PROD_W-1:0]  prod
);
   import pm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== design/pm_merge.sv =====
// merges lane products: sum across lanes, accumulate over passes, round and saturate
// depends on pm_pkg
module pm_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  pm_pkg::tag_type                   tag,
   input  logic signed [pm_pkg::PROD_W-1:0]  prod [pm_pkg::LANES],
   output pm_pkg::res_type                   res
);
   import pm_pkg::*;

   tag_type                  tag1_ff, tag2_ff, tag3_ff;
   logic signed [ACC_W-1:0]  sum_in, sum_ff, acc_ff, rnd;
   logic [ACC_W-48:0]        top;
   logic                     over;

   always_comb begin
      sum_in = '0;
      for (int l = 0; l < LANES; l++) begin
         sum_in = sum_in + ACC_W'(prod[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (tag2_ff.valid) begin
         acc_ff <= tag2_ff.first ? sum_ff : acc_ff + sum_ff;
      end
   end

   // round half up into q16.16, then clamp to 32 bits
   assign rnd  = acc_ff + ACC_W'(32'sh8000);
   assign top  = rnd[ACC_W-1:47];
   assign over = !((&top) || !(|top));

   always_comb begin
      res.valid = tag3_ff.valid && tag3_ff.last;
      res.power = tag3_ff.power;
      res.sat   = over;
      if (over) begin
         res.value = rnd[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         res.value = rnd[47:16];
      end
   end

endmodule

// ===== design/polynomial_multiplier.sv =====
// top level of the polynomial multiplier: load control, term sequencing, result buffer
// depends on pm_pkg, pm_store, pm_lane, pm_merge
//
// req channel: one coefficient pair per request, lowest power first, tdata holds
// the first and second polynomial coefficients (signed q16.16); tlast marks the
// final pair and starts the product. pairs past MAX_TERMS are dropped and flagged.
// while loading, one request is taken every cycle.
// rsp channel: one response per product term, power 0 up to degA + degB, tlast on
// the highest term, tuser set on every term of a product if a pair was dropped or
// any term saturated.
// each term runs ceil(MAX_TERMS / 4) passes through four multiplier lanes, one pass
// a cycle; each term is then read out of the result buffer and shown on rsp.
// req_tready is low from the final pair until the last term is taken.
// a stalled receiver simply holds the current term; nothing is lost.
// reset empties the load and returns to accepting pairs; the stores are not cleared.
module polynomial_multiplier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pm_pkg::REQ_TDATA_W-1:0]      req_tdata,  // coef_first, coef_second
   input  logic                                req_tlast,  // operands_done
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // term_power, term_value, pad
   output logic                                rsp_tlast,  // last_term
   output logic                                rsp_tuser   // overflow_seen
);
   import pm_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CALC,
      ST_WAIT,
      ST_READ,
      ST_SHOW
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DW-1:0]     deg_a_ff, deg_b_ff;
   logic              drop_ff, sat_ff;
   logic [PW-1:0]     pass_ff;
   logic [TW-1:0]     power_ff, last_power_ff, rd_idx_ff;
   logic [POWER_W-1:0] rsp_power_ff;
   logic [COEF_W-1:0] rsp_value_ff;
   logic              rsp_last_ff, rsp_user_ff;
   logic [COEF_W-1:0] term_buf [MAX_RES];

   logic              req_acc, store_wr;
   logic signed [COEF_W-1:0] coef_a, coef_b;
   logic signed [COEF_W-1:0] op_a [LANES];
   logic signed [COEF_W-1:0] op_b [LANES];
   logic signed [PROD_W-1:0] prod [LANES];
   tag_type           tag_in;
   res_type           res;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign store_wr   = req_acc && (cnt_ff < CW'(MAX_TERMS));
   assign coef_a     = req_tdata[COEF_W-1:0];
   assign coef_b     = req_tdata[2*COEF_W-1:COEF_W];

   assign tag_in.valid = (state_ff == ST_CALC);
   assign tag_in.first = (pass_ff == '0);
   assign tag_in.last  = (pass_ff == PW'(PASSES - 1));
   assign tag_in.power = power_ff;

   pm_store u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (cnt_ff),
      .wr_first  (coef_a),
      .wr_second (coef_b),
      .pass      (pass_ff),
      .power     (power_ff),
      .count     (cnt_ff),
      .op_a      (op_a),
      .op_b      (op_b)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      pm_lane u_lane (
         .clock (clock),
         .op_a  (op_a[l]),
         .op_b  (op_b[l]),
         .prod  (prod[l])
      );
   end

   pm_merge u_merge (
      .clock (clock),
      .reset (reset),
      .tag   (tag_in),
      .prod  (prod),
      .res   (res)
   );

   // result buffer: written by the merge stage, read into the output register
   always_ff @(posedge clock) begin
      if (res.valid) begin
         term_buf[res.power] <= res.value;
      end
      if (state_ff == ST_READ) begin
         rsp_value_ff <= term_buf[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         deg_a_ff      <= '0;
         deg_b_ff      <= '0;
         drop_ff       <= 1'b0;
         sat_ff        <= 1'b0;
         pass_ff       <= '0;
         power_ff      <= '0;
         last_power_ff <= '0;
         rd_idx_ff     <= '0;
         rsp_power_ff  <= '0;
         rsp_last_ff   <= 1'b0;
         rsp_user_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (store_wr) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (coef_a != '0) deg_a_ff <= DW'(cnt_ff);
                  if (coef_b != '0) deg_b_ff <= DW'(cnt_ff);
               end else if (req_acc) begin
                  drop_ff <= 1'b1;
               end
               if (req_acc && req_tlast) begin
                  state_ff <= ST_CALC;
                  pass_ff  <= '0;
                  power_ff <= '0;
                  sat_ff   <= 1'b0;
               end
            end
            ST_CALC: begin
               last_power_ff <= TW'(deg_a_ff) + TW'(deg_b_ff);
               if (pass_ff == PW'(PASSES - 1)) begin
                  pass_ff <= '0;
                  if (power_ff == TW'(deg_a_ff) + TW'(deg_b_ff)) begin
                     state_ff <= ST_WAIT;
                  end else begin
                     power_ff <= power_ff + 1'b1;
                  end
               end else begin
                  pass_ff <= pass_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (res.valid && res.power == last_power_ff) begin
                  state_ff  <= ST_READ;
                  rd_idx_ff <= '0;
               end
            end
            ST_READ: begin
               rsp_power_ff <= POWER_W'(rd_idx_ff);
               rsp_last_ff  <= (rd_idx_ff == last_power_ff);
               rsp_user_ff  <= drop_ff || sat_ff;
               state_ff     <= ST_SHOW;
            end
            ST_SHOW: begin
               if (rsp_tready) begin
                  if (rsp_last_ff) begin
                     state_ff <= ST_LOAD;
                     cnt_ff   <= '0;
                     deg_a_ff <= '0;
                     deg_b_ff <= '0;
                     drop_ff  <= 1'b0;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + 1'b1;
                     state_ff  <= ST_READ;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
         if (res.valid && res.sat) begin
            sat_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = (state_ff == ST_SHOW);
   assign rsp_tdata  = {3'b000, rsp_value_ff, rsp_power_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/pm_checker.sv =====
// port-level checks for the polynomial multiplier, bound to the top level
// depends on polynomial_multiplier_defines.svh
`include "polynomial_multiplier_defines.svh"

module pm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled term holds its contents
   `PM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no new pairs are taken while terms are being shown
   `PM_ASSERT_SAME(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)

   // the final pair closes the load
   `PM_ASSERT_NEXT(a_load_closed, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

   // after the highest term the block returns to loading
   `PM_ASSERT_NEXT(a_back_to_load, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && req_tready)

endmodule

bind polynomial_multiplier pm_checker u_pm_checker (.*);

// ===== tb/sv/polynomial_multiplier_checker.sv =====
`timescale 1ns / 1ps
// checker for the polynomial multiplier: watches req and rsp, predicts product terms
// depends on pm_pkg for the channel widths
module polynomial_multiplier_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tuser,
   output int                             failures,
   output int                             terms_pending
);
   import pm_pkg::*;

   typedef struct {
      logic [POWER_W-1:0] power;
      logic [31:0]        value;
      logic               last;
      logic               ovf;
   } term_t;

   logic signed [31:0] poly_a [MAX_TERMS];
   logic signed [31:0] poly_b [MAX_TERMS];
   int   pairs_held;
   bit   pair_dropped;
   term_t expected_terms [$];

   assign terms_pending = expected_terms.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      failures++;
   endtask

   function automatic int degree(input logic signed [31:0] p [MAX_TERMS]);
      int d;
      d = 0;
      for (int i = 0; i < pairs_held; i++)
         if (p[i] != 0) d = i;
      return d;
   endfunction

   // exact sum of q32.32 products, round half up, saturate
   task automatic multiply_out();
      int da, db, n;
      bit sat;
      logic signed [79:0] acc;
      logic signed [79:0] r;
      logic signed [31:0] vals [2*MAX_TERMS];
      term_t t;
      da = degree(poly_a);
      db = degree(poly_b);
      n = da + db + 1;
      sat = 0;
      for (int k = 0; k < n; k++) begin
         acc = 0;
         for (int i = 0; i <= da; i++)
            if (k - i >= 0 && k - i <= db)
               acc += 80'(poly_a[i]) * 80'(poly_b[k-i]);
         r = (acc + 80'sd32768) >>> 16;
         if (r > 80'sd2147483647) begin
            vals[k] = 32'h7fffffff; sat = 1;
         end else if (r < -80'sd2147483648) begin
            vals[k] = 32'h80000000; sat = 1;
         end else begin
            vals[k] = r[31:0];
         end
      end
      for (int k = 0; k < n; k++) begin
         t.power = k[POWER_W-1:0];
         t.value = vals[k];
         t.last  = (k == n - 1);
         t.ovf   = pair_dropped | sat;
         expected_terms.push_back(t);
      end
      pairs_held = 0;
      pair_dropped = 0;
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      term_t t;
      if (reset) begin
         pairs_held = 0;
         pair_dropped = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_terms.size() == 0) begin
               report("unexpected term", rsp_tdata, 0);
            end else begin
               t = expected_terms.pop_front();
               if (rsp_tdata[POWER_W-1:0] !== t.power)
                  report("term_power", rsp_tdata[POWER_W-1:0], t.power);
               if (rsp_tdata[POWER_W+31:POWER_W] !== t.value)
                  report("term_value", rsp_tdata[POWER_W+31:POWER_W], t.value);
               if (rsp_tlast !== t.last) report("last_term", rsp_tlast, t.last);
               if (rsp_tuser !== t.ovf) report("overflow_seen", rsp_tuser, t.ovf);
            end
         end
         if (req_tvalid && req_tready) begin
            if (pairs_held < MAX_TERMS) begin
               poly_a[pairs_held] = req_tdata[31:0];
               poly_b[pairs_held] = req_tdata[63:32];
               pairs_held++;
            end else begin
               pair_dropped = 1;
            end
            if (req_tlast) multiply_out();
         end
      end
   end
endmodule

// ===== tb/sv/polynomial_multiplier_tb.sv =====
`timescale 1ns / 1ps
// top of the polynomial multiplier testbench: clock, reset, request stimulus, verdict
// depends on pm_pkg, polynomial_multiplier and polynomial_multiplier_checker
module polynomial_multiplier_tb;
   import pm_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // coef_first, coef_second
   logic                   req_tlast;   // operands_done
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // term_power, term_value, pad
   logic                   rsp_tlast;   // last_term
   logic                   rsp_tuser;   // overflow_seen
   int                     failures;
   int                     terms_pending;
   int                     burst_left;

   polynomial_multiplier dut (.*);

   polynomial_multiplier_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver stall pattern: phases of always ready, random, and mostly stalled
   initial begin
      int mode;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         mode = int'(($time / 4000) % 3);
         if (mode == 0) rsp_tready <= 1;
         else if (mode == 1) rsp_tready <= $urandom_range(0, 1);
         else rsp_tready <= ($urandom_range(0, 4) == 0);
      end
   end

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 0;
         3: return 0;
         4: return 32'h00010000;
         5: return 32'hffff0000;
         6, 7: return $urandom;
         default: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
      endcase
   endfunction

   // one request, held until accepted; random gap before it when a burst runs out
   task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic done);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= {b, a};
      req_tlast  <= done;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_poly(input int len, input int kind);
      logic [31:0] a, b;
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: begin a = pick_coef(); b = pick_coef(); end
            1: begin a = 32'h7fffffff; b = 32'h7fffffff; end
            2: begin a = 32'h80000000; b = 32'h80000000; end
            default: begin a = $urandom; b = $urandom; end
         endcase
         send_pair(a, b, i == len - 1);
      end
   endtask

   initial begin
      int items;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: single pair, zero polys, extremes, saturation, overflow
      send_pair(0, 0, 1);
      send_pair(32'h00010000, 32'h00010000, 1);
      send_pair(32'h7fffffff, 32'h80000000, 1);
      send_pair(32'h00008000, 32'h00000001, 1);
      send_pair(32'hffffffff, 32'h00008000, 1);
      send_poly(3, 1);
      send_poly(2, 2);
      send_pair(0, 32'h00020000, 0);
      send_pair(0, 0, 1);
      send_poly(MAX_TERMS, 3);
      send_poly(MAX_TERMS + 2, 0);
      req_tvalid <= 0;
      // let the checker record the final request before looking at the queue
      @(posedge clock);
      while (terms_pending != 0) @(posedge clock);
      items = 46;
      while (items < 160) begin
         int len;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_TERMS - 1, MAX_TERMS + 3)
                                           : $urandom_range(1, 6);
         send_poly(len, ($urandom_range(0, 9) == 0) ? 1 : (($urandom_range(0, 3) == 0) ? 3 : 0));
         items += len;
      end
      req_tvalid <= 0;
      req_tlast  <= 0;
      @(posedge clock);
      while (terms_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) $display("[polynomial_multiplier] OK");
      else $display("[polynomial_multiplier] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[polynomial_multiplier] ERROR");
      $finish;
   end
endmodule
